>>> src/tcpg_pkg.sv
// Shared types, constants and small lookup functions for the test-card pattern generator.
`default_nettype none

package tcpg_pkg;

	localparam int MAX_DIM  = 4096;
	localparam int CFG_W    = 13;
	localparam int DIM_W    = CFG_W;
	localparam int SEC_W    = DIM_W - 2;
	localparam int COORD_W  = 12;
	localparam int CHAN_W   = 8;
	localparam int Q_W      = 8;
	localparam int DIV_W    = SEC_W + Q_W;
	localparam int RESET_DIM = 512;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam logic [CHAN_W-1:0] LVL_ZERO = 8'd0;
	localparam logic [CHAN_W-1:0] LVL_DIM  = 8'd51;
	localparam logic [CHAN_W-1:0] LVL_MID  = 8'd127;
	localparam logic [CHAN_W-1:0] LVL_FLAT = 8'd204;
	localparam logic [CHAN_W-1:0] LVL_FULL = 8'd255;

	typedef enum logic [2:0] {
		PAT_FLAT,
		PAT_RAMP,
		PAT_CHECK,
		PAT_STRIPE,
		PAT_DOT
	} pat_t;

	typedef struct packed {
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
		logic              outside;
	} color_t;

	// Everything about a pixel except the ramp quotient, carried beside the divider.
	typedef struct packed {
		logic              outside;
		logic              beyond;
		logic              is_ramp;
		logic [CHAN_W-1:0] level;
		logic [1:0]        lit;
	} side_t;

	// Section pattern is (row*4 + col) mod 5.
	function automatic pat_t pat_of(input logic [1:0] row, input logic [1:0] col);
		pat_t p;
		case ({row, col})
			4'd0, 4'd5, 4'd10, 4'd15: p = PAT_FLAT;
			4'd1, 4'd6, 4'd11:        p = PAT_RAMP;
			4'd2, 4'd7, 4'd12:        p = PAT_CHECK;
			4'd3, 4'd8, 4'd13:        p = PAT_STRIPE;
			default:                  p = PAT_DOT;
		endcase
		return p;
	endfunction

	// Lit color channel is col mod 3.
	function automatic logic [1:0] lit_of(input logic [1:0] col);
		logic [1:0] c;
		case (col)
			2'd1:    c = CH_GREEN;
			2'd2:    c = CH_BLUE;
			default: c = CH_RED;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/test_card_pattern_generator_top.sv
// Top level of the test-card pattern generator: config registers, section pipeline, output.
//
//  channel  | handshake         | payload        | notes
//  ---------+-------------------+----------------+--------------------------------
//  pixel    | start, busy       | pixel (pixel_t)| taken when start is high and busy low
//  result   | done              | result(color_t)| valid for the single cycle done is high
//  config   | cfg_we            | cfg_index,     | index 0 image_width, 1 image_height
//           |                   | cfg_data       |
//
// One pixel is taken every cycle; busy is never raised. A result passes three section stages,
// eight divider stages for the ramp and the output register. Reset clears the valid bits and
// loads both dimensions with 512. The receiver cannot stall, so the pipeline always advances.
`default_nettype none

module test_card_pattern_generator_top
	import tcpg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire pixel_t           pixel,
	output logic                  done,
	output color_t                result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam logic [DIM_W-1:0] DIM_RST  = DIM_W'(RESET_DIM);
	localparam logic [DIM_W-1:0] SEC1_RST = DIM_W'(RESET_DIM / 4);
	localparam logic [DIM_W-1:0] SEC2_RST = DIM_W'(RESET_DIM / 2);
	localparam logic [DIM_W-1:0] SEC3_RST = DIM_W'((RESET_DIM / 4) * 3);
	localparam logic [DIM_W-1:0] SEC4_RST = DIM_W'((RESET_DIM / 4) * 4);

	// Configuration and derived section boundaries.
	logic [DIM_W-1:0] width_q, sec1_w_q, sec2_w_q, sec3_w_q, sec4_w_q;
	logic [DIM_W-1:0] height_q, sec1_h_q, sec2_h_q, sec3_h_q, sec4_h_q;
	logic [DIM_W-1:0] dim_new, sec1_new, sec2_new, sec3_new, sec4_new;

	always_comb begin
		if (32'(cfg_data) > 32'(MAX_DIM)) begin
			dim_new = DIM_W'(MAX_DIM);
		end else begin
			dim_new = cfg_data;
		end
		sec1_new = dim_new >> 2;
		sec2_new = sec1_new << 1;
		sec3_new = sec1_new + sec2_new;
		sec4_new = sec1_new << 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RST;
			sec1_w_q <= SEC1_RST;
			sec2_w_q <= SEC2_RST;
			sec3_w_q <= SEC3_RST;
			sec4_w_q <= SEC4_RST;
			height_q <= DIM_RST;
			sec1_h_q <= SEC1_RST;
			sec2_h_q <= SEC2_RST;
			sec3_h_q <= SEC3_RST;
			sec4_h_q <= SEC4_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q  <= dim_new;
					sec1_w_q <= sec1_new;
					sec2_w_q <= sec2_new;
					sec3_w_q <= sec3_new;
					sec4_w_q <= sec4_new;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= dim_new;
					sec1_h_q <= sec1_new;
					sec2_h_q <= sec2_new;
					sec3_h_q <= sec3_new;
					sec4_h_q <= sec4_new;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Stage 1: range checks and section column and row.
	logic [DIM_W-1:0] x_ext, y_ext;
	assign x_ext = {{(DIM_W-COORD_W){1'b0}}, pixel.pos_x};
	assign y_ext = {{(DIM_W-COORD_W){1'b0}}, pixel.pos_y};

	logic             valid_s1, outside_s1, beyond_s1;
	logic [1:0]       col_s1, row_s1;
	logic [DIM_W-1:0] x_s1, y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		outside_s1 <= (x_ext >= width_q) || (y_ext >= height_q);
		beyond_s1  <= (x_ext >= sec4_w_q) || (y_ext >= sec4_h_q);
		col_s1     <= (x_ext >= sec3_w_q) ? 2'd3 : (x_ext >= sec2_w_q) ? 2'd2 :
		              (x_ext >= sec1_w_q) ? 2'd1 : 2'd0;
		row_s1     <= (y_ext >= sec3_h_q) ? 2'd3 : (y_ext >= sec2_h_q) ? 2'd2 :
		              (y_ext >= sec1_h_q) ? 2'd1 : 2'd0;
		x_s1       <= x_ext;
		y_s1       <= y_ext;
	end

	// Stage 2: offsets inside the section, pattern and lit channel.
	logic [DIM_W-1:0] base_x, base_y, off_x_full, off_y_full;

	always_comb begin
		case (col_s1)
			2'd1:    base_x = sec1_w_q;
			2'd2:    base_x = sec2_w_q;
			2'd3:    base_x = sec3_w_q;
			default: base_x = '0;
		endcase
		case (row_s1)
			2'd1:    base_y = sec1_h_q;
			2'd2:    base_y = sec2_h_q;
			2'd3:    base_y = sec3_h_q;
			default: base_y = '0;
		endcase
		off_x_full = x_s1 - base_x;
		off_y_full = y_s1 - base_y;
	end

	logic             valid_s2, outside_s2, beyond_s2, check_s2, stripe_s2;
	logic [SEC_W-1:0] off_x_s2;
	logic [4:0]       cell_y_s2;
	pat_t             pat_s2;
	logic [1:0]       lit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		outside_s2 <= outside_s1;
		beyond_s2  <= beyond_s1;
		off_x_s2   <= off_x_full[SEC_W-1:0];
		cell_y_s2  <= off_y_full[4:0];
		check_s2   <= ~(x_s1[4] ^ y_s1[4]);
		stripe_s2  <= ~x_s1[3];
		pat_s2     <= pat_of(row_s1, col_s1);
		lit_s2     <= lit_of(col_s1);
	end

	// Stage 3: non-ramp level and the ramp dividend off_x * 255.
	logic signed [5:0]  dx, dy;
	logic signed [11:0] dist_sq;
	logic               dot_on;
	logic [CHAN_W-1:0]  level_c;

	always_comb begin
		dx      = $signed({1'b0, off_x_s2[4:0]}) - 6'sd16;
		dy      = $signed({1'b0, cell_y_s2}) - 6'sd16;
		dist_sq = 12'(dx * dx) + 12'(dy * dy);
		dot_on  = (dist_sq < 12'sd64);
		case (pat_s2)
			PAT_FLAT:   level_c = LVL_FLAT;
			PAT_CHECK:  level_c = check_s2 ? LVL_FULL : LVL_ZERO;
			PAT_STRIPE: level_c = stripe_s2 ? LVL_FULL : LVL_ZERO;
			PAT_DOT:    level_c = dot_on ? LVL_FULL : LVL_ZERO;
			default:    level_c = LVL_ZERO;
		endcase
	end

	logic             valid_s3;
	logic [DIV_W-1:0] dividend_s3;
	side_t            side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dividend_s3     <= {off_x_s2, {Q_W{1'b0}}} - {{Q_W{1'b0}}, off_x_s2};
		side_s3.outside <= outside_s2;
		side_s3.beyond  <= beyond_s2;
		side_s3.is_ramp <= (pat_s2 == PAT_RAMP);
		side_s3.level   <= level_c;
		side_s3.lit     <= lit_s2;
	end

	// Divider stages; the user must change the section width only while idle (unchecked).
	logic           div_valid;
	logic [Q_W-1:0] ramp_q;
	side_t          div_side;

	tcpg_ramp_div u_ramp_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.dividend  (dividend_s3),
		.divisor   (sec1_w_q[SEC_W-1:0]),
		.in_side   (side_s3),
		.out_valid (div_valid),
		.quotient  (ramp_q),
		.out_side  (div_side)
	);

	// Output register: channel assembly.
	color_t            color_c;
	logic [CHAN_W-1:0] lvl;

	always_comb begin
		lvl = div_side.is_ramp ? ramp_q : div_side.level;
		if (div_side.outside) begin
			color_c.red     = LVL_ZERO;
			color_c.green   = LVL_ZERO;
			color_c.blue    = LVL_ZERO;
			color_c.alpha   = LVL_ZERO;
			color_c.outside = 1'b1;
		end else if (div_side.beyond) begin
			color_c.red     = LVL_MID;
			color_c.green   = LVL_MID;
			color_c.blue    = LVL_MID;
			color_c.alpha   = LVL_MID;
			color_c.outside = 1'b0;
		end else begin
			color_c.red     = (div_side.lit == CH_RED)   ? lvl : LVL_DIM;
			color_c.green   = (div_side.lit == CH_GREEN) ? lvl : LVL_DIM;
			color_c.blue    = (div_side.lit == CH_BLUE)  ? lvl : LVL_DIM;
			color_c.alpha   = LVL_FULL;
			color_c.outside = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= color_c;
	end

endmodule

`default_nettype wire

>>> src/tcpg_ramp_div.sv
// Pipelined restoring divider for the ramp level, one quotient bit per stage.
`default_nettype none

module tcpg_ramp_div
	import tcpg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [SEC_W-1:0] divisor,
	input  wire side_t            in_side,
	output logic                  out_valid,
	output logic [Q_W-1:0]        quotient,
	output side_t                 out_side
);

	logic             valid_sd [Q_W];
	logic [DIV_W-1:0] rem_sd   [Q_W];
	logic [Q_W-1:0]   quo_sd   [Q_W];
	side_t            side_sd  [Q_W];

	logic [DIV_W-1:0] divisor_ext;
	assign divisor_ext = {{(DIV_W-SEC_W){1'b0}}, divisor};

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic             v_in;
		logic [DIV_W-1:0] r_in;
		logic [Q_W-1:0]   q_in;
		side_t            s_in;
		logic [DIV_W-1:0] trial;
		logic             take;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = dividend;
			assign q_in = '0;
			assign s_in = in_side;
		end else begin : g_next
			assign v_in = valid_sd[i-1];
			assign r_in = rem_sd[i-1];
			assign q_in = quo_sd[i-1];
			assign s_in = side_sd[i-1];
		end

		// The quotient stays below 256, so the shifted divisor never overflows.
		assign trial = divisor_ext << (Q_W - 1 - i);
		assign take  = (r_in >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sd[i] <= 1'b0;
			end else begin
				valid_sd[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_sd[i]  <= take ? (r_in - trial) : r_in;
			quo_sd[i]  <= {q_in[Q_W-2:0], take};
			side_sd[i] <= s_in;
		end
	end

	assign out_valid = valid_sd[Q_W-1];
	assign quotient  = quo_sd[Q_W-1];
	assign out_side  = side_sd[Q_W-1];

endmodule

`default_nettype wire

>>> tb/test_card_pattern_generator_top_tb.sv
// Self-checking testbench for the test-card pattern generator: directed table, then random phases.
`timescale 1ns / 1ps

module test_card_pattern_generator_top_tb;
	import tcpg_pkg::*;

	localparam int RESET_CYCLES  = 5;
	localparam int PIPE_LATENCY  = 12;
	localparam int STALL_LIMIT   = 400;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_PIXELS  = 96;

	localparam color_t OFF_IMAGE = {LVL_ZERO, LVL_ZERO, LVL_ZERO, LVL_ZERO, 1'b1};
	localparam color_t OFF_GRID  = {LVL_MID, LVL_MID, LVL_MID, LVL_MID, 1'b0};

	typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic        sel;
		int unsigned value;
		int unsigned px;
		int unsigned py;
		bit          fixed;
		color_t      want;
	} stim_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              busy;
	pixel_t            pixel     = '0;
	logic              done;
	color_t            result;
	logic              cfg_we    = 1'b0;
	logic              cfg_index = 1'b0;
	logic [CFG_W-1:0]  cfg_data  = '0;

	color_t      color_q[$];
	stim_row_t   stim_rows[$];
	int unsigned model_width  = RESET_DIM;
	int unsigned model_height = RESET_DIM;
	int          mismatches   = 0;
	int          pixels_sent  = 0;
	int          colors_seen  = 0;
	int          reg_writes   = 0;
	int          quiet_cycles = 0;

	test_card_pattern_generator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
		return (v > MAX_DIM) ? MAX_DIM : 32'(v);
	endfunction

	// Color of one pixel for the given image size.
	function automatic color_t test_card_color(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input int unsigned w, input int unsigned h);
		int unsigned sec_w, sec_h, col, row, off_x, off_y, lit;
		int          dx, dy;
		pat_t        pat;
		logic [CHAN_W-1:0] lvl;
		color_t      c;
		if (x >= w || y >= h)
			return OFF_IMAGE;
		sec_w = w / 4;
		sec_h = h / 4;
		if (x >= 4 * sec_w || y >= 4 * sec_h)
			return OFF_GRID;
		col   = x / sec_w;
		row   = y / sec_h;
		off_x = x - col * sec_w;
		off_y = y - row * sec_h;
		pat   = pat_t'((row * 4 + col) % 5);
		case (pat)
			PAT_FLAT:   lvl = LVL_FLAT;
			PAT_RAMP:   lvl = CHAN_W'((off_x * 255) / sec_w);
			PAT_CHECK:  lvl = (((x >> 4) + (y >> 4)) % 2 == 0) ? LVL_FULL : LVL_ZERO;
			PAT_STRIPE: lvl = (x % 16 < 8) ? LVL_FULL : LVL_ZERO;
			default: begin
				dx  = int'(off_x % 32) - 16;
				dy  = int'(off_y % 32) - 16;
				lvl = (dx * dx + dy * dy < 64) ? LVL_FULL : LVL_ZERO;
			end
		endcase
		lit       = col % 3;
		c.red     = (lit == CH_RED)   ? lvl : LVL_DIM;
		c.green   = (lit == CH_GREEN) ? lvl : LVL_DIM;
		c.blue    = (lit == CH_BLUE)  ? lvl : LVL_DIM;
		c.alpha   = LVL_FULL;
		c.outside = 1'b0;
		return c;
	endfunction

	// Mostly inside the image, sometimes in the strip beyond the grid, sometimes anywhere.
	function automatic logic [COORD_W-1:0] pick_coord(input int unsigned dim);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (dim == 0 || r == 0)
			return COORD_W'($urandom_range(0, MAX_DIM - 1));
		if (r == 1 && dim % 4 != 0)
			return COORD_W'($urandom_range(dim - dim % 4, dim - 1));
		return COORD_W'($urandom_range(0, dim - 1));
	endfunction

	function automatic logic [CFG_W-1:0] random_dim();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return CFG_W'($urandom_range(1, 8));
			2:       return CFG_W'($urandom_range(MAX_DIM + 1, (1 << CFG_W) - 1));
			3:       return CFG_W'(MAX_DIM);
			default: return CFG_W'($urandom_range(1, MAX_DIM));
		endcase
	endfunction

	task automatic add_pixel(input int unsigned x, input int unsigned y, input bit fixed,
			input color_t want);
		stim_row_t r;
		r.kind  = ROW_PIXEL;
		r.sel   = REG_IMAGE_WIDTH;
		r.value = 0;
		r.px    = x;
		r.py    = y;
		r.fixed = fixed;
		r.want  = want;
		stim_rows.push_back(r);
	endtask

	task automatic add_cfg(input logic sel, input int unsigned value);
		stim_row_t r;
		r.kind  = ROW_CONFIG;
		r.sel   = sel;
		r.value = value;
		r.px    = 0;
		r.py    = 0;
		r.fixed = 1'b0;
		r.want  = '0;
		stim_rows.push_back(r);
	endtask

	// Offers one pixel and holds it until the block takes it.
	task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input bit fixed, input color_t want);
		pixel_t p;
		p.pos_x = x;
		p.pos_y = y;
		cfg_we <= 1'b0;
		start  <= 1'b1;
		pixel  <= p;
		do
			@(posedge clk);
		while (busy);
		color_q.push_back(fixed ? want : test_card_color(x, y, model_width, model_height));
		pixels_sent++;
	endtask

	task automatic take_break(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// The write enable is left high; the next pixel transaction lowers it.
	task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
		start <= 1'b0;
		while (color_q.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(posedge clk);
		if (sel == REG_IMAGE_WIDTH)
			model_width = clamp_dim(value);
		else
			model_height = clamp_dim(value);
		reg_writes++;
	endtask

	task automatic report_mismatch(input string what, input color_t want, input color_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected r=%0d g=%0d b=%0d a=%0d out=%0b",
				$realtime, what, want.red, want.green, want.blue, want.alpha, want.outside);
			$display("    got r=%0d g=%0d b=%0d a=%0d out=%0b",
				got.red, got.green, got.blue, got.alpha, got.outside);
		end
	endtask

	always @(posedge clk) begin : check_colors
		color_t want;
		if (arst_n && done) begin
			colors_seen++;
			if (color_q.size() == 0) begin
				report_mismatch("color with no pixel pending", '0, result);
			end else begin
				want = color_q.pop_front();
				if (result.red !== want.red || result.green !== want.green ||
						result.blue !== want.blue || result.alpha !== want.alpha ||
						result.outside !== want.outside)
					report_mismatch("color mismatch", want, result);
			end
		end
	end

	// A stall counts every cycle in which neither a pixel nor a color moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int idle_pct;

		// Reset size is 512 square, sections of 128.
		add_pixel(0, 0, 1, {LVL_FLAT, LVL_DIM, LVL_DIM, LVL_FULL, 1'b0});
		add_pixel(4095, 4095, 1, OFF_IMAGE);
		add_pixel(511, 511, 1, {LVL_FLAT, LVL_DIM, LVL_DIM, LVL_FULL, 1'b0});
		add_pixel(512, 0, 1, OFF_IMAGE);
		add_pixel(0, 512, 1, OFF_IMAGE);
		add_pixel(128, 0, 1, {LVL_DIM, LVL_ZERO, LVL_DIM, LVL_FULL, 1'b0});
		add_pixel(255, 0, 0, '0);
		add_pixel(256, 0, 1, {LVL_DIM, LVL_DIM, LVL_FULL, LVL_FULL, 1'b0});
		add_pixel(272, 0, 1, {LVL_DIM, LVL_DIM, LVL_ZERO, LVL_FULL, 1'b0});
		add_pixel(384, 0, 1, {LVL_FULL, LVL_DIM, LVL_DIM, LVL_FULL, 1'b0});
		add_pixel(392, 0, 1, {LVL_ZERO, LVL_DIM, LVL_DIM, LVL_FULL, 1'b0});
		add_pixel(16, 144, 0, '0);
		add_pixel(0, 128, 0, '0);
		// Sizes that leave strips beyond the grid.
		add_cfg(REG_IMAGE_WIDTH, 514);
		add_cfg(REG_IMAGE_HEIGHT, 6);
		add_pixel(513, 0, 1, OFF_GRID);
		add_pixel(0, 5, 1, OFF_GRID);
		// Below four pixels there are no sections at all.
		add_cfg(REG_IMAGE_WIDTH, 3);
		add_cfg(REG_IMAGE_HEIGHT, 3);
		add_pixel(0, 0, 1, OFF_GRID);
		add_pixel(2, 2, 1, OFF_GRID);
		add_pixel(3, 0, 1, OFF_IMAGE);
		add_cfg(REG_IMAGE_WIDTH, 0);
		add_pixel(0, 0, 1, OFF_IMAGE);
		// Oversized writes saturate to the largest image.
		add_cfg(REG_IMAGE_WIDTH, (1 << CFG_W) - 1);
		add_cfg(REG_IMAGE_HEIGHT, 5000);
		add_pixel(4095, 4095, 1, {LVL_FLAT, LVL_DIM, LVL_DIM, LVL_FULL, 1'b0});
		add_pixel(4095, 0, 1, {LVL_ZERO, LVL_DIM, LVL_DIM, LVL_FULL, 1'b0});
		add_pixel(2047, 0, 0, '0);
		add_cfg(REG_IMAGE_WIDTH, MAX_DIM);
		add_cfg(REG_IMAGE_HEIGHT, MAX_DIM);
		add_pixel(1024, 1024, 0, '0);
		add_cfg(REG_IMAGE_WIDTH, 4);
		add_cfg(REG_IMAGE_HEIGHT, 4);
		add_pixel(1, 0, 0, '0);
		add_pixel(3, 3, 0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CONFIG)
				write_reg(stim_rows[i].sel, CFG_W'(stim_rows[i].value));
			else
				send_pixel(COORD_W'(stim_rows[i].px), COORD_W'(stim_rows[i].py),
					stim_rows[i].fixed, stim_rows[i].want);
		end

		// Each phase starts from a drained pipeline, which also covers the sender pause.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_reg(REG_IMAGE_WIDTH, random_dim());
			write_reg(REG_IMAGE_HEIGHT, random_dim());
			idle_pct = (phase == 1 || phase == RANDOM_PHASES - 1) ? 0 : 30;
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				send_pixel(pick_coord(model_width), pick_coord(model_height), 0, '0);
				if ($urandom_range(0, 99) < idle_pct)
					take_break($urandom_range(1, 4));
			end
		end

		start  <= 1'b0;
		cfg_we <= 1'b0;
		while (color_q.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (color_q.size() != 0)
			mismatches++;

		$display("Sent %0d pixels across %0d register writes; %0d colors compared.",
			pixels_sent, reg_writes, colors_seen);
		$display("Sizes ranged from empty and sub-section images to saturated 4096 squares.");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
src/tcpg_pkg.sv
src/tcpg_ramp_div.sv
src/test_card_pattern_generator_top.sv
tb/test_card_pattern_generator_top_tb.sv
